FILE: design/bgsv_pkg.sv
// Shared types and constants for the block-growth stack vector.
// No dependencies; imported by every module of the block but bgsv_mem.
`default_nettype none

package bgsv_pkg;

    localparam int unsigned CNT_W = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
    localparam logic [CNT_W-1:0] RST_INIT_CAP = 11'd16;
    localparam logic [CNT_W-1:0] RST_BLOCK_SIZE = 11'd16;

    // register index as decoded from paddr[2]
    localparam logic REG_INITIAL_CAP = 1'b0;
    localparam logic REG_BLOCK_SIZE = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_GET  = 2'd2,
        CMD_SET  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OVERFLOW   = 3'd1,
        ST_ALLOC_FAIL = 3'd2,
        ST_UNDERFLOW  = 3'd3,
        ST_BAD_INDEX  = 3'd4
    } status_t;

    typedef struct packed {
        logic             wr_init;
        logic             wr_block;
        logic [CNT_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        status_t          status;
        logic             use_rdata;
        logic [CNT_W-1:0] count_now;
        logic [CNT_W-1:0] capacity_now;
    } result_t;

endpackage

`default_nettype wire

FILE: design/block_growth_stack_vector.sv
// Top level: APB register port, request pipeline and result register.
// Depends on bgsv_pkg, bgsv_ctrl and bgsv_mem.
//
// Stack of signed 32-bit items with push, pop, indexed get and indexed set,
// kept in a single-port RAM of DEPTH words. A logical capacity starts at
// initial_capacity (APB offset 0x0) and grows by block_size (offset 0x4)
// when a push finds the stack full; a pop may give back two blocks when the
// slack allows. Writing initial_capacity reloads the capacity and empties
// the stack. Every transaction returns one result: status, the item read
// (pop/get, zero otherwise), and the count and capacity after the step.
// Timing: an accepted transaction moves through stage 1 (RAM read in
// flight) and then the result register, and the block sustains one
// transaction per clock while m_ready stays high.
// Count and capacity update at the accept edge, so the next transaction
// sees them at once; RAM writes land at that edge too, so a later read of
// the same entry needs no bypass. The RAM has no reset and no clearing
// pass: every entry below the count has been written.
`default_nettype none

module block_growth_stack_vector #(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // APB register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // request channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_command,
    input  wire logic [9:0]         s_item_index,
    input  wire logic signed [31:0] s_item_value,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic signed [31:0]      m_read_value,
    output logic [10:0]             m_count_now,
    output logic [10:0]             m_capacity_now
);
    import bgsv_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    cfg_wr_t          cfg_wr;
    mem_ctl_t         mem_ctl;
    logic [AW-1:0]    mem_addr;
    result_t          res;
    logic [CNT_W-1:0] init_cap_reg;
    logic [CNT_W-1:0] block_size_reg;
    logic signed [31:0] rdata_reg;

    // stage 1: RAM read in flight
    logic    p1_valid_reg, p1_valid_next;
    result_t p1_res_reg;
    // stage 2: result register
    logic    m_valid_reg, m_valid_next;
    logic [2:0]         m_status_reg;
    logic signed [31:0] m_read_value_reg;
    logic [10:0]        m_count_reg;
    logic [10:0]        m_cap_reg;

    logic accept;
    logic p1_move;

    // APB: zero wait states, register picked by paddr[2]
    assign pready = 1'b1;
    always_comb begin
        cfg_wr.data     = pwdata[CNT_W-1:0];
        cfg_wr.wr_init  = psel && penable && pwrite && (paddr[2] == REG_INITIAL_CAP);
        cfg_wr.wr_block = psel && penable && pwrite && (paddr[2] == REG_BLOCK_SIZE);
        prdata = (paddr[2] == REG_BLOCK_SIZE) ? 32'(block_size_reg) : 32'(init_cap_reg);
    end

    // Stage 1 drains into the result register whenever that one is empty
    // or being taken; a new transaction enters behind it in the same cycle.
    assign p1_move = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_move;
    assign accept  = s_valid && s_ready;

    bgsv_ctrl #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr        (cfg_wr),
        .accept        (accept),
        .command       (s_command),
        .item_index    (s_item_index),
        .mem_ctl       (mem_ctl),
        .mem_addr      (mem_addr),
        .res           (res),
        .init_cap_reg  (init_cap_reg),
        .block_size_reg(block_size_reg)
    );

    bgsv_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .aclk     (aclk),
        .rd_en    (mem_ctl.rd_en),
        .wr_en    (mem_ctl.wr_en),
        .addr     (mem_addr),
        .wdata    (s_item_value),
        .rdata_reg(rdata_reg)
    );

    always_comb begin
        p1_valid_next = accept ? 1'b1 : (p1_move ? 1'b0 : p1_valid_reg);
        m_valid_next  = p1_move ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= res;
        end
        if (p1_move) begin
            m_status_reg <= p1_res_reg.status;
            // read data only for a successful pop or get
            m_read_value_reg <= (p1_res_reg.use_rdata && p1_res_reg.status == ST_OK)
                                ? rdata_reg : 32'sd0;
            m_count_reg <= p1_res_reg.count_now;
            m_cap_reg   <= p1_res_reg.capacity_now;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_read_value   = m_read_value_reg;
    assign m_count_now    = m_count_reg;
    assign m_capacity_now = m_cap_reg;

endmodule

`default_nettype wire

FILE: design/bgsv_mem.sv
// Single-port item store with registered read.
// Uses no package; instantiated by the top level.
`default_nettype none

module bgsv_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        addr,
    input  wire logic signed [31:0]   wdata,
    output logic signed [31:0]        rdata_reg
);

    logic signed [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/bgsv_ctrl.sv
// Count, capacity and config registers; decides status and memory access.
// Depends on bgsv_pkg.
`default_nettype none

module bgsv_ctrl #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire bgsv_pkg::cfg_wr_t          cfg_wr,
    input  wire logic                       accept,
    input  wire logic [1:0]                 command,
    input  wire logic [9:0]                 item_index,
    output bgsv_pkg::mem_ctl_t              mem_ctl,
    output logic [AW-1:0]                   mem_addr,
    output bgsv_pkg::result_t               res,
    output logic [bgsv_pkg::CNT_W-1:0]      init_cap_reg,
    output logic [bgsv_pkg::CNT_W-1:0]      block_size_reg
);
    import bgsv_pkg::*;

    localparam logic [16:0] DEPTH_W = 17'(DEPTH);
    localparam logic [11:0] GROW_LIMIT = (DEPTH < 2047) ? 12'(DEPTH) : 12'd2047;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg, cap_next;

    logic        full;
    logic [11:0] grown;
    logic        at_end;
    logic [11:0] two_blocks;
    logic [11:0] slack;
    logic        shrink;
    logic        idx_ok;
    status_t     status;
    logic        rd_want, wr_want;

    always_comb begin
        full       = count_reg >= cap_reg;
        grown      = {1'b0, cap_reg} + {1'b0, block_size_reg};
        at_end     = {6'b0, count_reg} >= DEPTH_W;
        two_blocks = {block_size_reg, 1'b0};
        slack      = {1'b0, cap_reg} - {1'b0, count_reg};
        shrink     = (block_size_reg != '0) && (cap_reg > init_cap_reg)
                     && (cap_reg >= count_reg) && (slack >= two_blocks);
        idx_ok     = ({1'b0, item_index} < count_reg) && ({7'b0, item_index} < DEPTH_W);

        status     = ST_OK;
        count_next = count_reg;
        cap_next   = cap_reg;
        rd_want    = 1'b0;
        wr_want    = 1'b0;
        mem_addr   = AW'(item_index);

        case (cmd_t'(command))
            CMD_PUSH: begin
                mem_addr = AW'(count_reg);
                if (full && block_size_reg == '0) begin
                    status = ST_OVERFLOW;
                end else if (full && grown > GROW_LIMIT) begin
                    status = ST_ALLOC_FAIL;
                end else if (at_end) begin
                    status = ST_ALLOC_FAIL;
                end else begin
                    wr_want    = 1'b1;
                    count_next = count_reg + 11'd1;
                    cap_next   = full ? grown[CNT_W-1:0] : cap_reg;
                end
            end
            CMD_POP: begin
                mem_addr = AW'(count_reg - 11'd1);
                if (count_reg == '0) begin
                    status = ST_UNDERFLOW;
                end else begin
                    rd_want    = 1'b1;
                    count_next = count_reg - 11'd1;
                    cap_next   = shrink ? (cap_reg - two_blocks[CNT_W-1:0]) : cap_reg;
                end
            end
            CMD_GET: begin
                if (idx_ok) begin
                    rd_want = 1'b1;
                end else begin
                    status = ST_BAD_INDEX;
                end
            end
            CMD_SET: begin
                if (idx_ok) begin
                    wr_want = 1'b1;
                end else begin
                    status = ST_BAD_INDEX;
                end
            end
            default: begin
                status = ST_BAD_INDEX;
            end
        endcase

        mem_ctl.rd_en    = accept && rd_want;
        mem_ctl.wr_en    = accept && wr_want;
        res.status       = status;
        res.use_rdata    = rd_want;
        res.count_now    = count_next;
        res.capacity_now = cap_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cap_reg   <= RST_INIT_CAP;
            block_size_reg <= RST_BLOCK_SIZE;
            cap_reg        <= RST_INIT_CAP;
            count_reg      <= '0;
        end else if (cfg_wr.wr_init) begin
            // reload capacity and empty the stack
            init_cap_reg <= cfg_wr.data;
            cap_reg      <= cfg_wr.data;
            count_reg    <= '0;
        end else begin
            if (cfg_wr.wr_block) begin
                block_size_reg <= cfg_wr.data;
            end
            if (accept) begin
                count_reg <= count_next;
                cap_reg   <= cap_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/bgsv_checker.sv
// Port-level checks for block_growth_stack_vector, bound to the top level.
// Depends on bgsv_pkg for status codes.
`default_nettype none

module bgsv_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [2:0]         m_status,
    input wire logic signed [31:0] m_read_value,
    input wire logic [10:0]        m_count_now,
    input wire logic [10:0]        m_capacity_now
);
    import bgsv_pkg::*;

    // stalled result holds (status, read value and count)
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_read_value) && $stable(m_count_now))
        else $error("result changed while stalled");

    // failed operations return no data
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_read_value == 32'sd0)
        else $error("nonzero read value on failed transaction");

    // shrinking never drops capacity below the count
    a_count_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count_now <= m_capacity_now)
        else $error("count exceeds capacity");

    // overflow only when the stack was at capacity, underflow only when empty
    a_fail_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OVERFLOW || m_status == ST_UNDERFLOW)
            |-> m_count_now == m_capacity_now || m_count_now == 11'd0)
        else $error("overflow or underflow with inconsistent count");

endmodule

bind block_growth_stack_vector bgsv_checker u_bgsv_checker (.*);

`default_nettype wire
